/* design/rpq_pkg.sv */
// Package for the ready priority queue: request codes, cell commands and
// the command group that the sequencer sends along the row of cells.
// No dependencies.
`default_nettype none

package rpq_pkg;

  // Request codes carried in s_axis_tuser
  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_APPEND = 3'd1;
  localparam logic [2:0] MODE_POP    = 3'd2;
  localparam logic [2:0] MODE_PEEK   = 3'd3;
  localparam logic [2:0] MODE_SETRDY = 3'd4;

  // Cell operations
  localparam logic [2:0] OP_HOLD   = 3'd0;
  localparam logic [2:0] OP_SCAN   = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_SETRDY = 3'd4;
  localparam logic [2:0] OP_DONE   = 3'd5;

  // What stops the search token in a valid cell
  localparam logic [1:0] MK_NONE  = 2'd0;
  localparam logic [1:0] MK_LOWER = 2'd1;
  localparam logic [1:0] MK_READY = 2'd2;
  localparam logic [1:0] MK_ID    = 2'd3;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] kind;
    logic       req_rdy;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* design/rpq_cell.sv */
// One queue cell: holds an entry and the search token, and shifts its
// entry to or from its neighbours. Depends on rpq_pkg.
`default_nettype none

module rpq_cell #(
  parameter int ID_BITS       = 8,
  parameter int PRIORITY_BITS = 3
) (
  input  wire                       clk,
  input  wire                       rst,
  input  rpq_pkg::cell_cmd_t        cmd,
  input  wire [ID_BITS-1:0]         req_id,
  input  wire [PRIORITY_BITS-1:0]   req_prio,
  input  wire                       left_valid,
  input  wire [ID_BITS-1:0]         left_id,
  input  wire [PRIORITY_BITS-1:0]   left_prio,
  input  wire                       left_rdy,
  input  wire                       left_passed,
  input  wire                       left_pass,
  input  wire                       right_valid,
  input  wire [ID_BITS-1:0]         right_id,
  input  wire [PRIORITY_BITS-1:0]   right_prio,
  input  wire                       right_rdy,
  output logic                      valid,
  output logic [ID_BITS-1:0]        id,
  output logic [PRIORITY_BITS-1:0]  prio,
  output logic                      rdy,
  output logic                      passed,
  output logic                      pass_out,
  output logic                      tok,
  output logic                      hit,
  output logic                      found
);

  logic                     match;
  logic                     valid_next;
  logic [ID_BITS-1:0]       id_next;
  logic [PRIORITY_BITS-1:0] prio_next;
  logic                     rdy_next;
  logic                     tok_next;
  logic                     passed_next;

  always_comb begin
    case (cmd.kind)
      rpq_pkg::MK_LOWER: match = (prio < req_prio);
      rpq_pkg::MK_READY: match = rdy;
      rpq_pkg::MK_ID:    match = (id == req_id);
      default:           match = 1'b0;
    endcase
  end

  // token halts at a match or at the first empty cell
  assign hit      = tok & (~valid | match);
  assign found    = tok & valid & match;
  assign pass_out = tok & ~hit;

  always_comb begin
    valid_next  = valid;
    id_next     = id;
    prio_next   = prio;
    rdy_next    = rdy;
    tok_next    = tok;
    passed_next = passed;
    unique case (cmd.op)
      rpq_pkg::OP_HOLD: begin
      end
      rpq_pkg::OP_SCAN: begin
        tok_next    = hit | left_pass;
        passed_next = passed | pass_out;
      end
      rpq_pkg::OP_INSERT: begin
        if (!passed) begin
          if (left_passed) begin
            valid_next = 1'b1;
            id_next    = req_id;
            prio_next  = req_prio;
            rdy_next   = cmd.req_rdy;
          end else begin
            valid_next = left_valid;
            id_next    = left_id;
            prio_next  = left_prio;
            rdy_next   = left_rdy;
          end
        end
        tok_next    = 1'b0;
        passed_next = 1'b0;
      end
      rpq_pkg::OP_REMOVE: begin
        if (!passed) begin
          valid_next = right_valid;
          id_next    = right_id;
          prio_next  = right_prio;
          rdy_next   = right_rdy;
        end
        tok_next    = 1'b0;
        passed_next = 1'b0;
      end
      rpq_pkg::OP_SETRDY: begin
        if (tok) begin
          rdy_next = cmd.req_rdy;
        end
        tok_next    = 1'b0;
        passed_next = 1'b0;
      end
      rpq_pkg::OP_DONE: begin
        tok_next    = 1'b0;
        passed_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      rdy    <= 1'b0;
      tok    <= 1'b0;
      passed <= 1'b0;
    end else begin
      valid  <= valid_next;
      rdy    <= rdy_next;
      tok    <= tok_next;
      passed <= passed_next;
    end
  end

  always_ff @(posedge clk) begin
    id   <= id_next;
    prio <= prio_next;
  end

endmodule

`default_nettype wire

/* design/ready_priority_queue.sv */
// Ready priority queue for a thread scheduler: sequencer and row of cells.
// Depends on rpq_pkg and rpq_cell.
//
// Usage
//   Requests arrive as beats on the s_axis channel: the request code in
//   tuser, thread id, priority and ready flag in tdata. Each request gives
//   exactly one result beat on m_axis: found, id, priority, overflow flag and
//   the occupancy after the request.
//   A request walks a search token down the row of cells, one cell a cycle,
//   from the head to the insertion point, the first ready entry or the first
//   entry with the given id. The token walk sets the cost: the further the
//   target sits from the head (at the occupancy when nothing matches), the
//   longer the request takes. Then the cells shift or update, and then the
//   result register loads. A push into a full queue and an unknown code skip
//   the walk and the cell update. The next beat is taken in the cycle after
//   the result is loaded.
//   The result register parts the two sides: a new request is accepted while
//   an earlier result still waits; if the receiver stalls, the finished
//   result waits in the sequencer and s_axis_tready stays low until it moves.
//   Reset empties the queue and clears every ready flag at once.
`default_nettype none

module ready_priority_queue #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int ID_BITS       = 8,
  parameter int PRIORITY_BITS = 3,
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_W         = ID_BITS + PRIORITY_BITS + 1,
  localparam int IN_DATA_W    = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W        = ID_BITS + PRIORITY_BITS + 2 + CNT_W,
  localparam int OUT_DATA_W   = ((OUT_W + 7) / 8) * 8
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  // thread_id, priority_req, ready_req (lowest bit up), zero padded
  input  wire [IN_DATA_W-1:0]   s_axis_tdata,
  // mode
  input  wire [2:0]             s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  // found, out_thread_id, out_priority, overflow, occupancy (lowest bit up)
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]               state;
  logic [CNT_W-1:0]         count;
  logic [2:0]               mode_q;
  logic [ID_BITS-1:0]       id_q;
  logic [PRIORITY_BITS-1:0] prio_q;
  logic                     rdy_q;
  logic                     res_found;
  logic [ID_BITS-1:0]       res_id;
  logic [PRIORITY_BITS-1:0] res_prio;
  logic                     res_ovf;
  logic                     m_found;
  logic [ID_BITS-1:0]       m_id;
  logic [PRIORITY_BITS-1:0] m_prio;
  logic                     m_ovf;
  logic [CNT_W-1:0]         m_occ;

  rpq_pkg::cell_cmd_t       cmd;
  logic                     start;
  logic                     in_beat;
  logic                     in_push;
  logic                     is_full;
  logic                     out_free;

  logic                     c_valid  [QUEUE_DEPTH];
  logic [ID_BITS-1:0]       c_id     [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] c_prio   [QUEUE_DEPTH];
  logic                     c_rdy    [QUEUE_DEPTH];
  logic                     c_passed [QUEUE_DEPTH];
  logic                     c_pass   [QUEUE_DEPTH];
  logic                     c_tok    [QUEUE_DEPTH];
  logic                     c_hit    [QUEUE_DEPTH];
  logic                     c_found  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   tok_vec;
  logic [QUEUE_DEPTH-1:0]   valid_vec;

  logic                     any_hit;
  logic                     any_found;
  logic                     any_tok;
  logic [ID_BITS-1:0]       sel_id;
  logic [PRIORITY_BITS-1:0] sel_prio;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_beat       = s_axis_tvalid & s_axis_tready;
  assign is_full       = (count == CNT_W'(QUEUE_DEPTH));
  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign in_push       = (s_axis_tuser == rpq_pkg::MODE_INSERT) ||
                         (s_axis_tuser == rpq_pkg::MODE_APPEND);

  // Row of cells: head at index 0, new entries come in from the left
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     l_valid;
    logic [ID_BITS-1:0]       l_id;
    logic [PRIORITY_BITS-1:0] l_prio;
    logic                     l_rdy;
    logic                     l_passed;
    logic                     l_pass;
    logic                     r_valid;
    logic [ID_BITS-1:0]       r_id;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic                     r_rdy;

    if (i == 0) begin : g_head
      assign l_valid  = 1'b0;
      assign l_id     = '0;
      assign l_prio   = '0;
      assign l_rdy    = 1'b0;
      assign l_passed = 1'b1;
      assign l_pass   = start;
    end else begin : g_mid
      assign l_valid  = c_valid[i-1];
      assign l_id     = c_id[i-1];
      assign l_prio   = c_prio[i-1];
      assign l_rdy    = c_rdy[i-1];
      assign l_passed = c_passed[i-1];
      assign l_pass   = c_pass[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_id    = '0;
      assign r_prio  = '0;
      assign r_rdy   = 1'b0;
    end else begin : g_body
      assign r_valid = c_valid[i+1];
      assign r_id    = c_id[i+1];
      assign r_prio  = c_prio[i+1];
      assign r_rdy   = c_rdy[i+1];
    end

    rpq_cell #(
      .ID_BITS       (ID_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .req_id      (id_q),
      .req_prio    (prio_q),
      .left_valid  (l_valid),
      .left_id     (l_id),
      .left_prio   (l_prio),
      .left_rdy    (l_rdy),
      .left_passed (l_passed),
      .left_pass   (l_pass),
      .right_valid (r_valid),
      .right_id    (r_id),
      .right_prio  (r_prio),
      .right_rdy   (r_rdy),
      .valid       (c_valid[i]),
      .id          (c_id[i]),
      .prio        (c_prio[i]),
      .rdy         (c_rdy[i]),
      .passed      (c_passed[i]),
      .pass_out    (c_pass[i]),
      .tok         (c_tok[i]),
      .hit         (c_hit[i]),
      .found       (c_found[i])
    );

    assign tok_vec[i]   = c_tok[i];
    assign valid_vec[i] = c_valid[i];
  end

  // Gather status from the cell holding the token (at most one)
  always_comb begin
    any_hit   = 1'b0;
    any_found = 1'b0;
    any_tok   = 1'b0;
    sel_id    = '0;
    sel_prio  = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      any_hit   = any_hit | c_hit[i];
      any_found = any_found | c_found[i];
      any_tok   = any_tok | c_tok[i];
      sel_id    = sel_id | ({ID_BITS{c_found[i]}} & c_id[i]);
      sel_prio  = sel_prio | ({PRIORITY_BITS{c_found[i]}} & c_prio[i]);
    end
  end

  // Drive the cell command for the current phase
  always_comb begin
    start       = 1'b0;
    cmd.op      = rpq_pkg::OP_HOLD;
    cmd.req_rdy = rdy_q;
    unique case (mode_q) inside
      rpq_pkg::MODE_INSERT:                  cmd.kind = rpq_pkg::MK_LOWER;
      rpq_pkg::MODE_POP, rpq_pkg::MODE_PEEK: cmd.kind = rpq_pkg::MK_READY;
      rpq_pkg::MODE_SETRDY:                  cmd.kind = rpq_pkg::MK_ID;
      default:                               cmd.kind = rpq_pkg::MK_NONE;
    endcase
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          unique case (s_axis_tuser) inside
            rpq_pkg::MODE_INSERT, rpq_pkg::MODE_APPEND: begin
              if (!is_full) begin
                start  = 1'b1;
                cmd.op = rpq_pkg::OP_SCAN;
              end
            end
            rpq_pkg::MODE_POP, rpq_pkg::MODE_PEEK, rpq_pkg::MODE_SETRDY: begin
              start  = 1'b1;
              cmd.op = rpq_pkg::OP_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.op = rpq_pkg::OP_SCAN;
      end
      ST_APPLY: begin
        unique case (mode_q) inside
          rpq_pkg::MODE_INSERT, rpq_pkg::MODE_APPEND: cmd.op = rpq_pkg::OP_INSERT;
          rpq_pkg::MODE_POP:
            cmd.op = res_found ? rpq_pkg::OP_REMOVE : rpq_pkg::OP_DONE;
          rpq_pkg::MODE_SETRDY:
            cmd.op = res_found ? rpq_pkg::OP_SETRDY : rpq_pkg::OP_DONE;
          default: cmd.op = rpq_pkg::OP_DONE;
        endcase
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // raise valid as the result loads, drop it once the beat is taken
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            state <= start ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          // halt at the token's stop, or when it has run off the tail
          if (any_hit || !any_tok) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (cmd.op == rpq_pkg::OP_INSERT) begin
            count <= count + CNT_W'(1);
          end else if (cmd.op == rpq_pkg::OP_REMOVE) begin
            count <= count - CNT_W'(1);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      mode_q    <= s_axis_tuser;
      id_q      <= s_axis_tdata[ID_BITS-1:0];
      prio_q    <= s_axis_tdata[ID_BITS +: PRIORITY_BITS];
      rdy_q     <= s_axis_tdata[ID_BITS + PRIORITY_BITS];
      res_found <= 1'b0;
      res_id    <= '0;
      res_prio  <= '0;
      res_ovf   <= in_push & is_full;
    end
    if (state == ST_SCAN && (any_hit || !any_tok)) begin
      // an insert stopping at a lower entry reports nothing found
      if (mode_q != rpq_pkg::MODE_INSERT) begin
        res_found <= any_found;
      end
      if (mode_q == rpq_pkg::MODE_POP || mode_q == rpq_pkg::MODE_PEEK) begin
        res_id   <= sel_id;
        res_prio <= sel_prio;
      end
    end
    if (state == ST_DONE && out_free) begin
      m_found <= res_found;
      m_id    <= res_id;
      m_prio  <= res_prio;
      m_ovf   <= res_ovf;
      m_occ   <= count;
    end
  end

  assign m_axis_tdata = OUT_DATA_W'({m_occ, m_ovf, m_prio, m_id, m_found});

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_token_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vec))
    else $error("more than one search token in the row");

  a_idle_no_token: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (tok_vec == '0))
    else $error("search token left behind after a request");

  a_fill_matches_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(valid_vec) == int'(count)))
    else $error("filled cells disagree with occupancy");

  a_remove_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY && cmd.op == rpq_pkg::OP_REMOVE) |-> (count != '0))
    else $error("removal from an empty queue");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_ovf) |-> (m_occ == CNT_W'(QUEUE_DEPTH)))
    else $error("overflow reported while the queue had room");

endmodule

`default_nettype wire

/* tb/sv/tb_ready_priority_queue.sv */
// Self-checking bench for the ready priority queue: random and directed scheduler requests,
// with the expected replies predicted from a shadow copy of the queue.
// Depends on rpq_pkg and the ready_priority_queue RTL.
`default_nettype none

module tb_ready_priority_queue;

  localparam int DEPTH       = 16;
  localparam int ID_W        = 8;
  localparam int PRI_W       = 3;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IN_DATA_W   = ((ID_W + PRI_W + 1 + 7) / 8) * 8;
  localparam int REPLY_W     = ID_W + PRI_W + 2 + CNT_W;
  localparam int OUT_DATA_W  = ((REPLY_W + 7) / 8) * 8;
  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 2 * DEPTH + 8;
  localparam int PHASE_ITEMS = 308;

  // Codes past set ready: the block must leave the queue alone
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_MID   = 3'd6;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  // Cumulative odds (per hundred) of insert, append, pop, peek and set ready
  // for fill-heavy, drain-heavy and balanced stretches; the rest is spare codes
  localparam int MODE_ODDS [3][5] = '{'{45, 75, 82, 88, 97},
                                      '{10, 20, 55, 68, 97},
                                      '{25, 40, 64, 74, 97}};

  typedef enum int {PH_STEADY, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_phase_t;

  typedef struct {
    logic [2:0]       mode;
    logic [ID_W-1:0]  tid;
    logic [PRI_W-1:0] prio;
    logic             rdy;
    bit               hold_idle;  // wait for every reply before this beat
  } sched_req_t;

  // Packed lowest field last, so it lines up with m_axis_tdata
  typedef struct packed {
    logic [CNT_W-1:0] occupancy;
    logic             overflow;
    logic [PRI_W-1:0] prio;
    logic [ID_W-1:0]  tid;
    logic             found;
  } sched_reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // thread_id, priority_req, ready_req (lowest bit up), zero padded
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // mode
  logic [2:0]            s_axis_tuser = rpq_pkg::MODE_INSERT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  // found, out_thread_id, out_priority, overflow, occupancy (lowest bit up)
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  ready_priority_queue #(
    .QUEUE_DEPTH   (DEPTH),
    .ID_BITS       (ID_W),
    .PRIORITY_BITS (PRI_W)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow of the queue, head at index 0
  logic [ID_W-1:0]  shadow_id  [DEPTH];
  logic [PRI_W-1:0] shadow_pri [DEPTH];
  logic             shadow_rdy [DEPTH];
  int               shadow_count = 0;

  sched_req_t   request_q [$];  // beats still to be offered
  sched_reply_t reply_q   [$];  // replies predicted for accepted beats
  sched_req_t   offered;        // beat currently on s_axis
  sched_reply_t mon_got, mon_want;
  idle_phase_t  phase = PH_STEADY;

  int  fail_count = 0;
  int  accepted = 0;
  int  checked = 0;
  int  overflows = 0;
  int  misses = 0;
  bit  took, load, gap;

  initial begin
    forever #4 clk = ~clk;
  end

  // Work out the reply to one accepted request and advance the shadow queue
  task automatic schedule_request(input sched_req_t r);
    sched_reply_t rep;
    int pos;
    rep = '0;
    pos = -1;
    case (r.mode) inside
      rpq_pkg::MODE_INSERT, rpq_pkg::MODE_APPEND: begin
        if (shadow_count >= DEPTH) begin
          rep.overflow = 1'b1;
          overflows++;
        end else begin
          pos = shadow_count;
          // insert goes in front of the first strictly lower priority
          if (r.mode == rpq_pkg::MODE_INSERT)
            for (int i = shadow_count - 1; i >= 0; i--)
              if (shadow_pri[i] < r.prio) pos = i;
          for (int j = shadow_count; j > pos; j--) begin
            shadow_id[j]  = shadow_id[j-1];
            shadow_pri[j] = shadow_pri[j-1];
            shadow_rdy[j] = shadow_rdy[j-1];
          end
          shadow_id[pos]  = r.tid;
          shadow_pri[pos] = r.prio;
          shadow_rdy[pos] = r.rdy;
          shadow_count++;
        end
      end
      rpq_pkg::MODE_POP, rpq_pkg::MODE_PEEK: begin
        for (int i = shadow_count - 1; i >= 0; i--)
          if (shadow_rdy[i]) pos = i;
        if (pos >= 0) begin
          rep.found = 1'b1;
          rep.tid   = shadow_id[pos];
          rep.prio  = shadow_pri[pos];
          if (r.mode == rpq_pkg::MODE_POP) begin
            for (int j = pos; j + 1 < shadow_count; j++) begin
              shadow_id[j]  = shadow_id[j+1];
              shadow_pri[j] = shadow_pri[j+1];
              shadow_rdy[j] = shadow_rdy[j+1];
            end
            shadow_count--;
          end
        end else begin
          misses++;
        end
      end
      rpq_pkg::MODE_SETRDY: begin
        // only the first entry with that id, counted from the head
        for (int i = shadow_count - 1; i >= 0; i--)
          if (shadow_id[i] == r.tid) pos = i;
        if (pos >= 0) begin
          shadow_rdy[pos] = r.rdy;
          rep.found = 1'b1;
        end
      end
      default: ;
    endcase
    rep.occupancy = shadow_count[CNT_W-1:0];
    reply_q.push_back(rep);
  endtask

  function automatic sched_req_t make_req(input logic [2:0] mode, input logic [ID_W-1:0] tid,
                                          input logic [PRI_W-1:0] prio, input logic rdy);
    sched_req_t r;
    r.mode = mode;
    r.tid = tid;
    r.prio = prio;
    r.rdy = rdy;
    r.hold_idle = 0;
    return r;
  endfunction

  // Random traffic in stretches that lean towards filling, draining or neither,
  // so the queue swings between empty and full. Ids mostly come from a small
  // pool so that set ready hits entries and duplicates turn up.
  task automatic add_random_requests(input int count);
    sched_req_t r;
    int left, bias, roll;
    left = 0;
    bias = 0;
    for (int n = 0; n < count; n++) begin
      if (left == 0) begin
        bias = $urandom_range(0, 2);
        left = $urandom_range(8, 40);
      end
      left--;
      roll = $urandom_range(0, 99);
      if (roll < MODE_ODDS[bias][0])      r.mode = rpq_pkg::MODE_INSERT;
      else if (roll < MODE_ODDS[bias][1]) r.mode = rpq_pkg::MODE_APPEND;
      else if (roll < MODE_ODDS[bias][2]) r.mode = rpq_pkg::MODE_POP;
      else if (roll < MODE_ODDS[bias][3]) r.mode = rpq_pkg::MODE_PEEK;
      else if (roll < MODE_ODDS[bias][4]) r.mode = rpq_pkg::MODE_SETRDY;
      else r.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      r.tid  = ($urandom_range(0, 99) < 80) ? ID_W'($urandom_range(0, 15))
                                            : ID_W'($urandom_range(0, 255));
      r.prio = PRI_W'($urandom_range(0, 7));
      r.rdy  = $urandom_range(0, 99) < 60;
      // open each batch of requests from a quiet block
      r.hold_idle = (n == 0);
      request_q.push_back(r);
    end
  endtask

  // Driver: offer the next pending beat once the current one is taken, with
  // random gaps as the phase asks. A beat marked hold_idle waits until every
  // reply has come back.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      took = s_axis_tvalid && s_axis_tready;
      if (took) begin
        schedule_request(offered);
        accepted++;
      end
      if (!s_axis_tvalid || took) begin
        gap = (phase == PH_SEND_IDLE && $urandom_range(0, 99) < 51) ||
              (phase == PH_BOTH && $urandom_range(0, 99) < 14);
        load = request_q.size() != 0 && !gap;
        if (load && request_q[0].hold_idle && (took || reply_q.size() != 0))
          load = 0;
        if (load) begin
          offered = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_DATA_W'({offered.rdy, offered.prio, offered.tid});
          s_axis_tuser  <= offered.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every result beat against the oldest prediction, then
  // decide whether to stall the next cycle
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      mon_got = sched_reply_t'(m_axis_tdata[REPLY_W-1:0]);
      if (reply_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result beat: found=%0b id=%02h pri=%0d ovf=%0b occ=%0d",
                   mon_got.found, mon_got.tid, mon_got.prio, mon_got.overflow,
                   mon_got.occupancy);
      end else begin
        mon_want = reply_q.pop_front();
        checked++;
        if (mon_got.found !== mon_want.found || mon_got.tid !== mon_want.tid ||
            mon_got.prio !== mon_want.prio || mon_got.overflow !== mon_want.overflow ||
            mon_got.occupancy !== mon_want.occupancy) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"result %0d: expected found=%0b id=%02h pri=%0d ovf=%0b occ=%0d,",
                      " got found=%0b id=%02h pri=%0d ovf=%0b occ=%0d"},
                     checked, mon_want.found, mon_want.tid, mon_want.prio,
                     mon_want.overflow, mon_want.occupancy, mon_got.found, mon_got.tid,
                     mon_got.prio, mon_got.overflow, mon_got.occupancy);
        end
      end
    end
    case (phase)
      PH_RECV_STALL: m_axis_tready <= $urandom_range(0, 99) >= 51;
      PH_BOTH:       m_axis_tready <= $urandom_range(0, 99) >= 14;
      default:       m_axis_tready <= 1'b1;
    endcase
  end

  // Guard against a hung handshake
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    // Directed opening: empty queue first, then a small hand-built queue
    request_q.push_back(make_req(rpq_pkg::MODE_POP,    8'h00, 3'd0, 1'b0));  // pop on empty
    request_q.push_back(make_req(rpq_pkg::MODE_PEEK,   8'hFF, 3'd7, 1'b1));  // peek on empty
    request_q.push_back(make_req(rpq_pkg::MODE_SETRDY, 8'h00, 3'd0, 1'b1));  // unknown id
    request_q.push_back(make_req(MODE_SPARE_FIRST,     8'hFF, 3'd7, 1'b1));  // spare codes
    request_q.push_back(make_req(MODE_SPARE_MID,       8'h00, 3'd0, 1'b0));
    request_q.push_back(make_req(MODE_SPARE_LAST,      8'hAA, 3'd5, 1'b1));
    request_q.push_back(make_req(rpq_pkg::MODE_INSERT, 8'h00, 3'd0, 1'b0));
    request_q.push_back(make_req(rpq_pkg::MODE_PEEK,   8'h00, 3'd0, 1'b0));  // nothing ready
    request_q.push_back(make_req(rpq_pkg::MODE_INSERT, 8'hFF, 3'd7, 1'b1));  // to the head
    request_q.push_back(make_req(rpq_pkg::MODE_INSERT, 8'hA5, 3'd7, 1'b1));  // equal, behind
    request_q.push_back(make_req(rpq_pkg::MODE_APPEND, 8'h5A, 3'd7, 1'b0));  // tail
    request_q.push_back(make_req(rpq_pkg::MODE_INSERT, 8'h3C, 3'd3, 1'b1));  // before prio 0
    request_q.push_back(make_req(rpq_pkg::MODE_SETRDY, 8'h5A, 3'd0, 1'b1));
    request_q.push_back(make_req(rpq_pkg::MODE_APPEND, 8'h3C, 3'd1, 1'b0));  // duplicate id
    request_q.push_back(make_req(rpq_pkg::MODE_SETRDY, 8'h3C, 3'd2, 1'b0));  // first copy
    request_q.push_back(make_req(rpq_pkg::MODE_PEEK,   8'h11, 3'd4, 1'b0));
    request_q.push_back(make_req(rpq_pkg::MODE_POP,    8'h00, 3'd0, 1'b0));
    request_q.push_back(make_req(rpq_pkg::MODE_POP,    8'h00, 3'd0, 1'b0));
    request_q.push_back(make_req(rpq_pkg::MODE_POP,    8'h00, 3'd0, 1'b0));  // mid-queue
    request_q.push_back(make_req(rpq_pkg::MODE_POP,    8'h00, 3'd0, 1'b0));  // none ready
    request_q.push_back(make_req(rpq_pkg::MODE_SETRDY, 8'h00, 3'd6, 1'b1));
    request_q.push_back(make_req(rpq_pkg::MODE_POP,    8'h00, 3'd0, 1'b0));
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Random traffic through each idling phase; change phase only once the
    // previous phase's beats have all been offered
    for (int p = PH_STEADY; p <= PH_BOTH; p++) begin
      @(negedge clk);
      while (request_q.size() != 0) @(negedge clk);
      phase = idle_phase_t'(p);
      add_random_requests(PHASE_ITEMS);
    end

    @(negedge clk);
    while (request_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (reply_q.size() != 0) begin
      fail_count++;
      $display("%0d predicted results never arrived", reply_q.size());
    end

    $display("%0d requests accepted across steady, sender-gap, receiver-stall and mixed",
             accepted);
    $display("%0d results checked, %0d pushes dropped on a full queue,", checked, overflows);
    $display("%0d pops/peeks found nothing", misses);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d failures", fail_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
